### rtl/csfd_pkg.sv
`timescale 1ns / 1ps

package csfd_pkg;

  localparam int FRAME_LENGTH = 28;
  localparam int POS_W        = 9;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] FRAME_LEN_P  = POS_W'(FRAME_LENGTH);
  localparam logic [POS_W-1:0] TRAILER_POS  = POS_W'(FRAME_LENGTH - 2);

  localparam logic [15:0] CRC_POLY = 16'h8005;

  // payload field offsets within the frame
  localparam logic [POS_W-1:0] POS_MAGIC_FIRST  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_MAGIC_SECOND = POS_W'(1);
  localparam logic [POS_W-1:0] POS_VERSION      = POS_W'(2);
  localparam logic [POS_W-1:0] POS_PAYLOAD_LEN  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_FLAGS        = POS_W'(4);
  localparam logic [POS_W-1:0] POS_IP           = POS_W'(6);
  localparam logic [POS_W-1:0] POS_MASK         = POS_W'(10);
  localparam logic [POS_W-1:0] POS_GATEWAY      = POS_W'(14);
  localparam logic [POS_W-1:0] POS_MAIN_MV      = POS_W'(18);
  localparam logic [POS_W-1:0] POS_AUX_MV       = POS_W'(20);
  localparam logic [POS_W-1:0] POS_AGE          = POS_W'(22);

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_FIRST  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_SECOND = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VERSION      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LEN  = 8'd3;

  localparam int OUT_BITS  = 179;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int OUT_W     = OUT_BYTES * 8;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_LENGTH  = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_PLEN    = 3'd4,
    ST_BAD_CRC     = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] magic_first;
    logic [7:0] magic_second;
    logic [7:0] protocol_version;
    logic [7:0] expected_payload_length;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       last;
    logic [7:0] data;
  } step_t;

  // frame state after the current byte has been applied
  typedef struct packed {
    logic        length_ok;
    logic        crc_span;
    status_t     err;
    logic [15:0] trailer;
    logic [15:0] status_flags;
    logic [31:0] ip_address;
    logic [31:0] net_mask;
    logic [31:0] gateway_address;
    logic [15:0] main_voltage_mv;
    logic [15:0] aux_voltage_mv;
    logic [31:0] source_age_ms;
  } capture_t;

  // reflected-input, left-shifting CRC over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = b[i] ^ c[15];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

endpackage

### rtl/csfd_crc.sv
`timescale 1ns / 1ps

module csfd_crc (
  input  logic              clk,
  input  logic              rst,
  input  csfd_pkg::step_t   step,
  input  logic              crc_en,
  output logic [15:0]       crc_next
);
  import csfd_pkg::*;

  logic [15:0] crc;

  assign crc_next = crc_en ? crc_byte(crc, step.data) : crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= '0;
    end else if (step.accept) begin
      crc <= step.last ? 16'h0000 : crc_next;
    end
  end

endmodule

### rtl/csfd_frame.sv
`timescale 1ns / 1ps

module csfd_frame (
  input  logic                clk,
  input  logic                rst,
  input  csfd_pkg::step_t     step,
  input  csfd_pkg::cfg_t      cfg,
  output csfd_pkg::capture_t  cap_next
);
  import csfd_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  capture_t         cap;
  logic             in_frame;

  function automatic logic [15:0] put16(input logic [15:0] w, input logic [7:0] b,
                                        input logic [POS_W-1:0] p,
                                        input logic [POS_W-1:0] base);
    logic [POS_W-1:0] off;
    logic [15:0]      r;
    off = p - base;
    r   = w;
    if (p >= base && off < POS_W'(2)) begin
      if (off[0]) r[15:8] = b;
      else        r[7:0]  = b;
    end
    return r;
  endfunction

  function automatic logic [31:0] put32(input logic [31:0] w, input logic [7:0] b,
                                        input logic [POS_W-1:0] p,
                                        input logic [POS_W-1:0] base);
    logic [POS_W-1:0] off;
    logic [31:0]      r;
    off = p - base;
    r   = w;
    if (p >= base && off < POS_W'(4)) begin
      case (off[1:0])
        2'd0:    r[7:0]   = b;
        2'd1:    r[15:8]  = b;
        2'd2:    r[23:16] = b;
        default: r[31:24] = b;
      endcase
    end
    return r;
  endfunction

  assign in_frame = pos < FRAME_LEN_P;
  assign pos_next = (pos == POS_MAX) ? pos : pos + POS_W'(1);

  always_comb begin
    cap_next           = cap;
    cap_next.length_ok = pos_next == FRAME_LEN_P;
    cap_next.crc_span  = pos < TRAILER_POS;
    if (in_frame) begin
      if (pos >= TRAILER_POS) begin
        cap_next.trailer = put16(cap.trailer, step.data, pos, TRAILER_POS);
      end
      // only the first header fault is kept
      if (cap.err == ST_OK) begin
        if ((pos == POS_MAGIC_FIRST && step.data != cfg.magic_first) ||
            (pos == POS_MAGIC_SECOND && step.data != cfg.magic_second)) begin
          cap_next.err = ST_BAD_MAGIC;
        end else if (pos == POS_VERSION && step.data != cfg.protocol_version) begin
          cap_next.err = ST_BAD_VERSION;
        end else if (pos == POS_PAYLOAD_LEN && step.data != cfg.expected_payload_length) begin
          cap_next.err = ST_BAD_PLEN;
        end
      end
      cap_next.status_flags    = put16(cap.status_flags, step.data, pos, POS_FLAGS);
      cap_next.ip_address      = put32(cap.ip_address, step.data, pos, POS_IP);
      cap_next.net_mask        = put32(cap.net_mask, step.data, pos, POS_MASK);
      cap_next.gateway_address = put32(cap.gateway_address, step.data, pos, POS_GATEWAY);
      cap_next.main_voltage_mv = put16(cap.main_voltage_mv, step.data, pos, POS_MAIN_MV);
      cap_next.aux_voltage_mv  = put16(cap.aux_voltage_mv, step.data, pos, POS_AUX_MV);
      cap_next.source_age_ms   = put32(cap.source_age_ms, step.data, pos, POS_AGE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      cap <= '0;
    end else if (step.accept) begin
      if (step.last) begin
        pos <= '0;
        cap <= '0;
      end else begin
        pos <= pos_next;
        cap <= cap_next;
      end
    end
  end

endmodule

### rtl/crc_checked_status_frame_decoder.sv
`timescale 1ns / 1ps
// A result word is registered and valid on m_tvalid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; s_tready stays high unless a result is stalled.
// Each byte updates the CRC and field captures in the cycle it is taken.
// Reset (rst, synchronous): clears configuration, frame state and m_tvalid.

module crc_checked_status_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tlast,    // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] status, [18:3] status_flags, [50:19] ip_address, [82:51] net_mask,
  // [114:83] gateway_address, [130:115] main_voltage_mv, [146:131] aux_voltage_mv,
  // [178:147] source_age_ms, rest zero
  output logic [csfd_pkg::OUT_W-1:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [csfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);
  import csfd_pkg::*;

  cfg_t     cfg;
  step_t    step;
  capture_t cap_next;
  logic [15:0] crc_next;
  status_t  status_next;
  logic [OUT_W-1:0] tdata_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAGIC_FIRST:  cfg.magic_first             <= cfg_data;
        REG_MAGIC_SECOND: cfg.magic_second            <= cfg_data;
        REG_VERSION:      cfg.protocol_version        <= cfg_data;
        REG_PAYLOAD_LEN:  cfg.expected_payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready    = !m_tvalid || m_tready;
  assign step.accept = s_tvalid && s_tready;
  assign step.last   = s_tlast;
  assign step.data   = s_tdata;

  csfd_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cfg      (cfg),
    .cap_next (cap_next)
  );

  csfd_crc u_crc (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .crc_en   (cap_next.crc_span),
    .crc_next (crc_next)
  );

  always_comb begin
    if (!cap_next.length_ok)            status_next = ST_BAD_LENGTH;
    else if (cap_next.err != ST_OK)     status_next = cap_next.err;
    else if (crc_next != cap_next.trailer) status_next = ST_BAD_CRC;
    else                                status_next = ST_OK;

    tdata_next      = '0;
    tdata_next[2:0] = status_next;
    if (status_next == ST_OK) begin
      tdata_next[18:3]    = cap_next.status_flags;
      tdata_next[50:19]   = cap_next.ip_address;
      tdata_next[82:51]   = cap_next.net_mask;
      tdata_next[114:83]  = cap_next.gateway_address;
      tdata_next[130:115] = cap_next.main_voltage_mv;
      tdata_next[146:131] = cap_next.aux_voltage_mv;
      tdata_next[178:147] = cap_next.source_age_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step.accept && step.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.accept && step.last) begin
      m_tdata <= tdata_next;
    end
  end

  a_last_gives_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("final byte did not produce a result word");

  a_no_spurious_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast && m_tready |=> !m_tvalid)
    else $error("result word without a final byte");

  a_error_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[OUT_W-1:3] == '0)
    else $error("payload not cleared on error status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ST_BAD_CRC)
    else $error("status code out of range");

endmodule
